// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int WORD_WIDTH_DEFAULT = 32;
   localparam int FUNC_WIDTH         = 3;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_QUERY      = 3'd0,
      FUNC_PUSH_FRONT = 3'd1,
      FUNC_PUSH_BACK  = 3'd2,
      FUNC_POP_FRONT  = 3'd3,
      FUNC_POP_BACK   = 3'd4
   } func_type;

   // per-cycle control broadcast along one chain of cells
   typedef struct packed {
      logic shift_in;    // everything moves one cell away from the head, new word at head
      logic shift_out;   // everything moves one cell toward the head
      logic write_tail;  // the cell at the current count takes the new word
   } cell_ctrl_type;

endpackage

// ===== rtl/deq_cell.sv =====
`timescale 1ns / 1ps

module deq_cell #(
   parameter int INDEX       = 0,
   parameter int WORD_WIDTH  = deq_pkg::WORD_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = 11
) (
   input  logic                      clock,
   input  deq_pkg::cell_ctrl_type    ctrl,
   input  logic [COUNT_WIDTH-1:0]    count,
   input  logic [WORD_WIDTH-1:0]     prev_data,
   input  logic [WORD_WIDTH-1:0]     next_data,
   input  logic [WORD_WIDTH-1:0]     push_data,
   output logic [WORD_WIDTH-1:0]     data_ff,
   output logic [WORD_WIDTH-1:0]     data_in
);
   import deq_pkg::*;

   logic at_tail;

   assign at_tail = (count == COUNT_WIDTH'(INDEX));

   always_comb begin
      priority if (ctrl.shift_in) begin
         data_in = prev_data;
      end else if (ctrl.shift_out) begin
         data_in = next_data;
      end else if (ctrl.write_tail && at_tail) begin
         data_in = push_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== rtl/deq_chain.sv =====
`timescale 1ns / 1ps

module deq_chain #(
   parameter int DEPTH       = deq_pkg::DEPTH_DEFAULT,
   parameter int WORD_WIDTH  = deq_pkg::WORD_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  deq_pkg::cell_ctrl_type    ctrl,
   input  logic [COUNT_WIDTH-1:0]    count,
   input  logic [WORD_WIDTH-1:0]     push_data,
   output logic [WORD_WIDTH-1:0]     head,
   output logic [WORD_WIDTH-1:0]     head_in
);
   import deq_pkg::*;

   logic [WORD_WIDTH-1:0] cell_data [DEPTH];
   logic [WORD_WIDTH-1:0] cell_next [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] prev_data;
      logic [WORD_WIDTH-1:0] next_data;

      if (i == 0) begin : g_head
         assign prev_data = push_data;
      end else begin : g_body
         assign prev_data = cell_data[i-1];
      end

      // last cell holds on a shift toward the head; its word is past the count then
      if (i == DEPTH - 1) begin : g_last
         assign next_data = cell_data[i];
      end else begin : g_inner
         assign next_data = cell_data[i+1];
      end

      deq_cell #(
         .INDEX      (i),
         .WORD_WIDTH (WORD_WIDTH),
         .COUNT_WIDTH(COUNT_WIDTH)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .count    (count),
         .prev_data(prev_data),
         .next_data(next_data),
         .push_data(push_data),
         .data_ff  (cell_data[i]),
         .data_in  (cell_next[i])
      );
   end

   assign head    = cell_data[0];
   assign head_in = cell_next[0];

endmodule

// ===== rtl/double_ended_queue_top.sv =====
`timescale 1ns / 1ps

// bounded double-ended queue of DEPTH words
// request channel: req_func picks query, push front, push back, pop front or pop back,
//   req_value is the word to push; codes beyond pop back act as a query
// response channel: one response per request with the popped word and its valid flag,
//   a dropped-push flag, the count, an empty flag and the front and back words
//   after the operation (words read as zero on an empty queue)
// the words live twice, in two rows of cells: one row keeps the front word in its
//   first cell, the other the back word; every push shifts one row by a cell and
//   writes the other at the cell that the count selects, a pop shifts only its own
//   row, so the ends sit at fixed places
// latency: the response is valid the cycle after the request transfer
// throughput: one request per cycle; a request is taken while the response register
//   is empty or being drained in the same cycle
// receiver stall: the response holds and req_ready drops until it is taken
// reset: the queue is empty and no response is pending; no clearing pass is needed
module double_ended_queue_top #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int WORD_WIDTH = deq_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [deq_pkg::FUNC_WIDTH-1:0]    req_func,
   input  logic signed [WORD_WIDTH-1:0]      req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [WORD_WIDTH-1:0]      rsp_pop_value,
   output logic                              rsp_pop_valid,
   output logic                              rsp_push_dropped,
   output logic [$clog2(DEPTH + 1)-1:0]      rsp_entry_total,
   output logic                              rsp_is_empty,
   output logic signed [WORD_WIDTH-1:0]      rsp_front_value,
   output logic signed [WORD_WIDTH-1:0]      rsp_back_value
);
   import deq_pkg::*;

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   logic                   transfer;
   logic                   is_full;
   logic                   not_empty;
   logic                   do_push_front;
   logic                   do_push_back;
   logic                   do_pop_front;
   logic                   do_pop_back;
   logic                   drop;
   cell_ctrl_type          front_ctrl;
   cell_ctrl_type          back_ctrl;
   logic [WORD_WIDTH-1:0]  front_head;
   logic [WORD_WIDTH-1:0]  front_head_in;
   logic [WORD_WIDTH-1:0]  back_head;
   logic [WORD_WIDTH-1:0]  back_head_in;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [WORD_WIDTH-1:0]  pop_value_ff;
   logic [WORD_WIDTH-1:0]  pop_value_in;
   logic                   pop_valid_ff;
   logic                   pop_valid_in;
   logic                   dropped_ff;
   logic [WORD_WIDTH-1:0]  front_value_ff;
   logic [WORD_WIDTH-1:0]  front_value_in;
   logic [WORD_WIDTH-1:0]  back_value_ff;
   logic [WORD_WIDTH-1:0]  back_value_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign transfer  = req_valid && req_ready;
   assign is_full   = (count_ff == COUNT_WIDTH'(DEPTH));
   assign not_empty = (count_ff != '0);

   always_comb begin
      do_push_front = 1'b0;
      do_push_back  = 1'b0;
      do_pop_front  = 1'b0;
      do_pop_back   = 1'b0;
      drop          = 1'b0;
      unique case (func_type'(req_func))
         FUNC_PUSH_FRONT: begin
            do_push_front = transfer && !is_full;
            drop          = is_full;
         end
         FUNC_PUSH_BACK: begin
            do_push_back = transfer && !is_full;
            drop         = is_full;
         end
         FUNC_POP_FRONT: begin
            do_pop_front = transfer && not_empty;
         end
         FUNC_POP_BACK: begin
            do_pop_back = transfer && not_empty;
         end
         default: begin
         end
      endcase
   end

   // a push at one end lands at the far end of the other row
   assign front_ctrl = '{shift_in: do_push_front, shift_out: do_pop_front,
                         write_tail: do_push_back};
   assign back_ctrl  = '{shift_in: do_push_back, shift_out: do_pop_back,
                         write_tail: do_push_front};

   deq_chain #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front_chain (
      .clock    (clock),
      .ctrl     (front_ctrl),
      .count    (count_ff),
      .push_data(req_value),
      .head     (front_head),
      .head_in  (front_head_in)
   );

   deq_chain #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back_chain (
      .clock    (clock),
      .ctrl     (back_ctrl),
      .count    (count_ff),
      .push_data(req_value),
      .head     (back_head),
      .head_in  (back_head_in)
   );

   always_comb begin
      priority if (do_push_front || do_push_back) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (do_pop_front || do_pop_back) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      priority if (do_pop_front) begin
         pop_value_in = front_head;
      end else if (do_pop_back) begin
         pop_value_in = back_head;
      end else begin
         pop_value_in = '0;
      end
   end

   assign pop_valid_in   = do_pop_front || do_pop_back;
   assign front_value_in = (count_in != '0) ? front_head_in : '0;
   assign back_value_in  = (count_in != '0) ? back_head_in : '0;
   assign rsp_valid_in   = transfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         pop_value_ff   <= pop_value_in;
         pop_valid_ff   <= pop_valid_in;
         dropped_ff     <= drop;
         front_value_ff <= front_value_in;
         back_value_ff  <= back_value_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pop_value    = pop_value_ff;
   assign rsp_pop_valid    = pop_valid_ff;
   assign rsp_push_dropped = dropped_ff;
   assign rsp_entry_total  = count_ff;
   assign rsp_is_empty     = (count_ff == '0);
   assign rsp_front_value  = front_value_ff;
   assign rsp_back_value   = back_value_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("entry count above depth");

   a_pop_or_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(pop_valid_ff && dropped_ff))
      else $error("response flags both a pop and a dropped push");

   a_pending_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(count_ff))
      else $error("queue changed while a response was pending");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      transfer && drop |=> dropped_ff && is_full)
      else $error("dropped push on a queue that is not full");

endmodule
